/* sv/hcbc_pkg.sv */
// Shared types and constants for the HSV color blob centroid block.
package hcbc_pkg;

  localparam int PIX_W  = 8;
  localparam int OUT_W  = 11;
  localparam int CFG_W  = 12;
  localparam int CFG_AW = 3;

  // Widths of the HSV dividers: numerator below 2^17, denominator up to 510.
  localparam int HSV_NUM_W = 17;
  localparam int HSV_DEN_W = 9;
  localparam int HSV_STEP_W = 5;

  localparam logic [PIX_W-1:0] HUE_WRAP = 8'd180;

  typedef enum logic [CFG_AW-1:0] {
    REG_HUE_LOW      = 3'd0,
    REG_SAT_LOW      = 3'd1,
    REG_VAL_LOW      = 3'd2,
    REG_HUE_HIGH     = 3'd3,
    REG_SAT_HIGH     = 3'd4,
    REG_VAL_HIGH     = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue_low;
    logic [PIX_W-1:0] sat_low;
    logic [PIX_W-1:0] val_low;
    logic [PIX_W-1:0] hue_high;
    logic [PIX_W-1:0] sat_high;
    logic [PIX_W-1:0] val_high;
  } thr_t;

  typedef struct packed {
    logic match;
    logic done;
  } pix_flags_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_WAIT
  } bstate_t;

endpackage

/* sv/hcbc_front.sv */
// Front end: takes a pixel, converts it to HSV, tests the bounds and tracks its position.
module hcbc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int XW         = 11,
  parameter int YW         = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [hcbc_pkg::PIX_W-1:0] in_blue,
  input  logic [hcbc_pkg::PIX_W-1:0] in_green,
  input  logic [hcbc_pkg::PIX_W-1:0] in_red,
  input  hcbc_pkg::thr_t             thr,
  input  logic [hcbc_pkg::CFG_W-1:0] frame_width,
  input  logic [hcbc_pkg::CFG_W-1:0] frame_height,
  input  logic                       q_full,
  output logic                       q_push,
  output hcbc_pkg::pix_flags_t       q_flags,
  output logic [XW-1:0]              q_x,
  output logic [YW-1:0]              q_y
);
  import hcbc_pkg::*;

  fstate_t state_r, state_nxt;
  logic [HSV_STEP_W-1:0] step_r;
  logic [XW-1:0] col_r;
  logic [YW-1:0] row_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic done_r;
  logic [PIX_W-1:0] v_r;
  logic [HSV_NUM_W-1:0] snum_r, hnum_r;
  logic [HSV_DEN_W-1:0] sden_r, hden_r, srem_r, hrem_r;
  logic [PIX_W-1:0] sq_r, hq_r;
  logic szero_r, hzero_r;

  logic accept;
  logic [PIX_W-1:0] mx, mn, d;
  logic signed [19:0] gs, bs, rs, ds, hs;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;
  logic row_end, done_now;
  logic [HSV_DEN_W:0] ssh, hsh;
  logic sbit, hbit;
  logic [PIX_W-1:0] hue, sat;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_push) state_nxt = F_DIV;
      F_DIV:   if (step_r == '0) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    case (state_r)
      F_IDLE:  in_full = 1'b0;
      F_PUSH:  q_push = !q_full;
      default: ;
    endcase
  end

  assign accept = in_push && !in_full;

  // Max, min and the two HSV numerators.
  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d  = mx - mn;
    gs = signed'(20'(in_green));
    bs = signed'(20'(in_blue));
    rs = signed'(20'(in_red));
    ds = signed'(20'(d));
    if (mx == in_red) begin
      hs = 20'sd60 * (gs - bs);
    end else if (mx == in_green) begin
      hs = 20'sd120 * ds + 20'sd60 * (bs - rs);
    end else begin
      hs = 20'sd240 * ds + 20'sd60 * (rs - gs);
    end
    if (hs < 0) hs = hs + 20'sd360 * ds;
  end

  // Position in the frame, with sizes clamped to the supported range.
  always_comb begin
    if (frame_width == '0) wm1 = '0;
    else if (32'(frame_width) > MAX_WIDTH) wm1 = XW'(MAX_WIDTH - 1);
    else wm1 = XW'(frame_width - 12'd1);
    if (frame_height == '0) hm1 = '0;
    else if (32'(frame_height) > MAX_HEIGHT) hm1 = YW'(MAX_HEIGHT - 1);
    else hm1 = YW'(frame_height - 12'd1);
    row_end  = col_r >= wm1;
    done_now = row_end && (row_r >= hm1);
  end

  // One restoring division step for saturation and hue each.
  always_comb begin
    ssh  = {srem_r, snum_r[HSV_NUM_W-1]};
    hsh  = {hrem_r, hnum_r[HSV_NUM_W-1]};
    sbit = ssh >= {1'b0, sden_r};
    hbit = hsh >= {1'b0, hden_r};
  end

  always_comb begin
    sat = szero_r ? '0 : sq_r;
    if (hzero_r) hue = '0;
    else if (hq_r >= HUE_WRAP) hue = hq_r - HUE_WRAP;
    else hue = hq_r;
    q_flags.match = (hue >= thr.hue_low) && (hue <= thr.hue_high) &&
                    (sat >= thr.sat_low) && (sat <= thr.sat_high) &&
                    (v_r >= thr.val_low) && (v_r <= thr.val_high);
    q_flags.done  = done_r;
    q_x = x_r;
    q_y = y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (done_now) begin
          col_r <= '0;
          row_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= col_r;
      y_r     <= (row_r <= hm1) ? (hm1 - row_r) : '0;
      done_r  <= done_now;
      v_r     <= mx;
      szero_r <= mx == '0;
      hzero_r <= d == '0;
      snum_r  <= HSV_NUM_W'(17'(d) * 17'd510) + HSV_NUM_W'(mx);
      hnum_r  <= HSV_NUM_W'(hs + ds);
      sden_r  <= {mx, 1'b0};
      hden_r  <= {d, 1'b0};
      srem_r  <= '0;
      hrem_r  <= '0;
      step_r  <= HSV_STEP_W'(HSV_NUM_W - 1);
    end else if (state_r == F_DIV) begin
      snum_r <= {snum_r[HSV_NUM_W-2:0], 1'b0};
      hnum_r <= {hnum_r[HSV_NUM_W-2:0], 1'b0};
      srem_r <= sbit ? HSV_DEN_W'(ssh - {1'b0, sden_r}) : ssh[HSV_DEN_W-1:0];
      hrem_r <= hbit ? HSV_DEN_W'(hsh - {1'b0, hden_r}) : hsh[HSV_DEN_W-1:0];
      sq_r   <= {sq_r[PIX_W-2:0], sbit};
      hq_r   <= {hq_r[PIX_W-2:0], hbit};
      step_r <= step_r - 1'b1;
    end
  end

endmodule

/* sv/hcbc_queue.sv */
// Small first-in first-out queue between the front and the back end.
module hcbc_queue #(
  parameter int W     = 24,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

/* sv/hcbc_back.sv */
// Back end: accumulates matching positions and divides out the centroid at frame end.
module hcbc_back #(
  parameter int XW = 11,
  parameter int YW = 11,
  parameter int CW = 23
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  hcbc_pkg::pix_flags_t        q_flags,
  input  logic [XW-1:0]               q_x,
  input  logic [YW-1:0]               q_y,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_in_range,
  output logic                        out_frame_done,
  output logic                        out_found,
  output logic [hcbc_pkg::OUT_W-1:0]  out_center_x,
  output logic [hcbc_pkg::OUT_W-1:0]  out_center_y
);
  import hcbc_pkg::*;

  localparam int PW  = (XW > YW) ? XW : YW;
  localparam int SW  = PW + CW;
  localparam int QW  = (PW > OUT_W) ? PW : OUT_W;
  localparam int SCW = $clog2(SW);

  bstate_t state_r, state_nxt;
  logic [SW-1:0] sx_r, sy_r, numx_r, numy_r;
  logic [CW-1:0] cnt_r, den_r, remx_r, remy_r;
  logic [QW-1:0] qx_r, qy_r;
  logic [SCW-1:0] step_r;
  logic match_l_r;
  logic out_vld_r, o_range_r, o_done_r, o_found_r;
  logic [OUT_W-1:0] o_cx_r, o_cy_r;

  logic out_free, take, load_plain, start_div, load_div;
  logic [SW-1:0] sx_add, sy_add;
  logic [CW-1:0] cnt_add;
  logic [CW:0] xsh, ysh;
  logic xbit, ybit;

  assign out_free = !out_vld_r || out_pop;
  assign sx_add   = sx_r + (q_flags.match ? SW'(q_x) : '0);
  assign sy_add   = sy_r + (q_flags.match ? SW'(q_y) : '0);
  assign cnt_add  = cnt_r + CW'(q_flags.match);
  assign xsh      = {remx_r, numx_r[SW-1]};
  assign ysh      = {remy_r, numy_r[SW-1]};
  assign xbit     = xsh >= {1'b0, den_r};
  assign ybit     = ysh >= {1'b0, den_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (start_div) state_nxt = B_DIV;
      B_DIV:   if (step_r == '0) state_nxt = B_WAIT;
      B_WAIT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    take       = 1'b0;
    load_plain = 1'b0;
    start_div  = 1'b0;
    load_div   = 1'b0;
    case (state_r)
      B_IDLE: begin
        take       = !q_empty && out_free;
        start_div  = take && q_flags.done && (cnt_add != '0);
        load_plain = take && !start_div;
      end
      B_WAIT:  load_div = out_free;
      default: ;
    endcase
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
      sx_r      <= '0;
      sy_r      <= '0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        if (q_flags.done) begin
          sx_r  <= '0;
          sy_r  <= '0;
          cnt_r <= '0;
        end else begin
          sx_r  <= sx_add;
          sy_r  <= sy_add;
          cnt_r <= cnt_add;
        end
      end
      if (load_plain || load_div) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      numx_r    <= sx_add;
      numy_r    <= sy_add;
      den_r     <= cnt_add;
      remx_r    <= '0;
      remy_r    <= '0;
      match_l_r <= q_flags.match;
      step_r    <= SCW'(SW - 1);
    end else if (state_r == B_DIV) begin
      numx_r <= {numx_r[SW-2:0], 1'b0};
      numy_r <= {numy_r[SW-2:0], 1'b0};
      remx_r <= xbit ? CW'(xsh - {1'b0, den_r}) : xsh[CW-1:0];
      remy_r <= ybit ? CW'(ysh - {1'b0, den_r}) : ysh[CW-1:0];
      qx_r   <= {qx_r[QW-2:0], xbit};
      qy_r   <= {qy_r[QW-2:0], ybit};
      step_r <= step_r - 1'b1;
    end
    if (load_plain) begin
      o_range_r <= q_flags.match;
      o_done_r  <= q_flags.done;
      o_found_r <= 1'b0;
      o_cx_r    <= '0;
      o_cy_r    <= '0;
    end else if (load_div) begin
      o_range_r <= match_l_r;
      o_done_r  <= 1'b1;
      o_found_r <= 1'b1;
      o_cx_r    <= qx_r[OUT_W-1:0];
      o_cy_r    <= qy_r[OUT_W-1:0];
    end
  end

  assign out_empty      = !out_vld_r;
  assign out_in_range   = o_range_r;
  assign out_frame_done = o_done_r;
  assign out_found      = o_found_r;
  assign out_center_x   = o_cx_r;
  assign out_center_y   = o_cy_r;

endmodule

/* sv/hsv_color_blob_centroid.sv */
// Top level of the HSV color threshold and blob centroid block.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_push / in_full    in_blue, in_green, in_red
//   out_      output     out_pop / out_empty  out_in_range, out_frame_done, out_found,
//                                              out_center_x, out_center_y
//   cfg_      input      cfg_we               cfg_addr, cfg_wdata
//
// The front end takes one pixel at a time: it accepts it and sets up the HSV
// numerators, runs the separate bit-serial saturation and hue dividers in parallel,
// and pushes the classified pixel into the queue before it accepts the next one.
// A pixel that closes a frame with matches also runs the bit-serial centroid
// division in the back end.
// Reset is synchronous and active low; it clears counters, sums, the queue and
// the output register, and loads the register reset values.
// Either side may stall on its own: a four-entry queue separates the front and
// back ends, and the output register holds a result until it is popped.
module hsv_color_blob_centroid #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [hcbc_pkg::PIX_W-1:0]  in_blue,
  input  logic [hcbc_pkg::PIX_W-1:0]  in_green,
  input  logic [hcbc_pkg::PIX_W-1:0]  in_red,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_in_range,
  output logic                        out_frame_done,
  output logic                        out_found,
  output logic [hcbc_pkg::OUT_W-1:0]  out_center_x,
  output logic [hcbc_pkg::OUT_W-1:0]  out_center_y,
  input  logic                        cfg_we,
  input  logic [hcbc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hcbc_pkg::CFG_W-1:0]  cfg_wdata
);
  import hcbc_pkg::*;

  // Column and row counters cover the largest frame; the match count covers
  // every pixel of it.
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int CW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int QDEPTH  = 4;
  localparam int QW      = $bits(pix_flags_t) + XW + YW;

  thr_t thr_r;
  logic [CFG_W-1:0] width_r, height_r;

  logic q_push, q_full, q_pop, q_empty;
  pix_flags_t f_flags, b_flags;
  logic [XW-1:0] f_x, b_x;
  logic [YW-1:0] f_y, b_y;
  logic [QW-1:0] q_rdata;

  // Config registers: the user writes only with no pixel in flight; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.hue_low  <= 8'd60;
      thr_r.sat_low  <= 8'd120;
      thr_r.val_low  <= 8'd70;
      thr_r.hue_high <= 8'd120;
      thr_r.sat_high <= 8'd255;
      thr_r.val_high <= 8'd255;
      width_r        <= 12'd640;
      height_r       <= 12'd480;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_HUE_LOW:      thr_r.hue_low  <= cfg_wdata[PIX_W-1:0];
        REG_SAT_LOW:      thr_r.sat_low  <= cfg_wdata[PIX_W-1:0];
        REG_VAL_LOW:      thr_r.val_low  <= cfg_wdata[PIX_W-1:0];
        REG_HUE_HIGH:     thr_r.hue_high <= cfg_wdata[PIX_W-1:0];
        REG_SAT_HIGH:     thr_r.sat_high <= cfg_wdata[PIX_W-1:0];
        REG_VAL_HIGH:     thr_r.val_high <= cfg_wdata[PIX_W-1:0];
        REG_FRAME_WIDTH:  width_r        <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front end converts and classifies each pixel and tags it with its
  // column, flipped row and an end-of-frame flag.
  hcbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .thr          (thr_r),
    .frame_width  (width_r),
    .frame_height (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_flags      (f_flags),
    .q_x          (f_x),
    .q_y          (f_y)
  );

  hcbc_queue #(
    .W     (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_flags, f_x, f_y}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_flags, b_x, b_y} = q_rdata;

  // The back end keeps the running sums and produces one transaction per
  // pixel on the result side.
  hcbc_back #(
    .XW (XW),
    .YW (YW),
    .CW (CW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_flags        (b_flags),
    .q_x            (b_x),
    .q_y            (b_y),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_in_range   (out_in_range),
    .out_frame_done (out_frame_done),
    .out_found      (out_found),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y)
  );

endmodule

/* sv/hcbc_checker.sv */
// Port-level checker for the HSV blob centroid block, with its bind statement.
module hcbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic                       out_frame_done,
  input logic                       out_found,
  input logic [hcbc_pkg::OUT_W-1:0] out_center_x,
  input logic [hcbc_pkg::OUT_W-1:0] out_center_y
);

  // Coming out of reset, no result waits and the input side is open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("block not empty and open after reset");

  // A centroid is reported only on the last pixel of a frame.
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_found |-> out_frame_done)
    else $error("found set outside frame end");

  // Without a match the centroid reads as zero.
  a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_found |-> out_center_x == '0 && out_center_y == '0)
    else $error("nonzero centroid without a match");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_found) &&
      $stable(out_center_x) && $stable(out_center_y))
    else $error("waiting result changed");

endmodule

bind hsv_color_blob_centroid hcbc_checker u_hcbc_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the HSV color threshold and blob centroid block.
`timescale 1ns / 1ps

module testbench;
  import hcbc_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PIXEL_GOAL  = 1900;
  localparam int SIZE_MAX    = 2048;

  // One classified pixel as the block reports it.
  typedef struct packed {
    logic             in_range;
    logic             frame_done;
    logic             found;
    logic [OUT_W-1:0] center_x;
    logic [OUT_W-1:0] center_y;
  } blob_result_t;

  // A directed pixel. Where known is set, the result is typed in here and
  // the frame is far from over, so only the match bit can be nonzero.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    bit         known;
    bit         known_match;
  } pixel_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [PIX_W-1:0] in_blue = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_red = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic             out_in_range;
  logic             out_frame_done;
  logic             out_found;
  logic [OUT_W-1:0] out_center_x;
  logic [OUT_W-1:0] out_center_y;
  logic             cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hsv_color_blob_centroid dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_in_range(out_in_range), .out_frame_done(out_frame_done), .out_found(out_found),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the registers and of the frame position and sums.
  int unsigned hue_lo, sat_lo, val_lo, hue_hi, sat_hi, val_hi;
  int unsigned width_reg, height_reg;
  int unsigned col_pos, row_pos;
  longint unsigned x_total, y_total, hit_count;

  blob_result_t pending_pixels[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  pixels_sent = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v);
    if (v < 1) return 1;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  // Classifies one pixel and advances the frame position, the same way the
  // block does for each accepted transaction.
  function automatic blob_result_t track_pixel(input logic [7:0] b, input logic [7:0] g,
                                               input logic [7:0] r);
    int mx, mn, d, num, h, s, v, flip;
    int unsigned w, ht;
    bit hit, row_end, done;
    blob_result_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = mx;
    s = (mx == 0) ? 0 : (510 * d + mx) / (2 * mx);
    h = 0;
    if (d != 0) begin
      if (mx == r) num = 60 * (int'(g) - int'(b));
      else if (mx == g) num = 120 * d + 60 * (int'(b) - int'(r));
      else num = 240 * d + 60 * (int'(r) - int'(g));
      if (num < 0) num += 360 * d;
      h = (num + d) / (2 * d);
      if (h >= 180) h -= 180;
    end
    hit = h >= hue_lo && h <= hue_hi && s >= sat_lo && s <= sat_hi &&
          v >= val_lo && v <= val_hi;
    w = clamp_size(width_reg);
    ht = clamp_size(height_reg);
    // Rows beyond a shrunken height count as the bottom row.
    flip = (row_pos <= ht - 1) ? int'(ht - 1 - row_pos) : 0;
    if (hit) begin
      x_total += col_pos;
      y_total += flip;
      hit_count++;
    end
    row_end = col_pos >= w - 1;
    done = row_end && row_pos >= ht - 1;
    res = '0;
    res.in_range = hit;
    res.frame_done = done;
    if (done) begin
      if (hit_count != 0) begin
        res.found = 1'b1;
        res.center_x = OUT_W'(x_total / hit_count);
        res.center_y = OUT_W'(y_total / hit_count);
      end
      x_total = 0; y_total = 0; hit_count = 0;
      col_pos = 0; row_pos = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  // Offers one pixel, starting at a rising edge, and returns at the edge that
  // accepted it. in_push is left high so that back-to-back pixels never see it
  // lowered and raised in the same step.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            output blob_result_t res);
    in_push <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (in_full);
    res = track_pixel(b, g, r);
    pixels_sent++;
  endtask

  // Waits until every result has come back, then lets the block settle.
  task automatic drain();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all eight registers, one per cycle, with the block idle.
  task automatic write_regs(input logic [CFG_W-1:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (reg_idx_t'(i))
        REG_HUE_LOW:      hue_lo = vals[i][7:0];
        REG_SAT_LOW:      sat_lo = vals[i][7:0];
        REG_VAL_LOW:      val_lo = vals[i][7:0];
        REG_HUE_HIGH:     hue_hi = vals[i][7:0];
        REG_SAT_HIGH:     sat_hi = vals[i][7:0];
        REG_VAL_HIGH:     val_hi = vals[i][7:0];
        REG_FRAME_WIDTH:  width_reg = vals[i];
        REG_FRAME_HEIGHT: height_reg = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: the stall pattern rotates through free flow, coin-flip stalls,
  // a periodic trickle of pops, and light stalls.
  always @(posedge clk) begin
    blob_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_in_range !== want.in_range)
          report("in_range", out_in_range, want.in_range);
        if (out_frame_done !== want.frame_done)
          report("frame_done", out_frame_done, want.frame_done);
        if (out_found !== want.found)
          report("found", out_found, want.found);
        if (out_center_x !== want.center_x)
          report("center_x", out_center_x, want.center_x);
        if (out_center_y !== want.center_y)
          report("center_y", out_center_y, want.center_y);
      end
    end
    case ((cycles >> 7) % 4)
      0: out_pop <= 1'b1;
      1: out_pop <= $urandom_range(1, 0);
      2: out_pop <= (cycles % 8 == 0);
      default: out_pop <= ($urandom_range(3, 0) != 0);
    endcase
  end

  pixel_row_t directed[] = '{
    '{8'd0,   8'd0,   8'd0,   1, 0},  // black: no saturation, no value
    '{8'd255, 8'd255, 8'd255, 1, 0},  // white: no saturation
    '{8'd0,   8'd255, 8'd0,   1, 1},  // pure green sits on the lower hue bound
    '{8'd255, 8'd0,   8'd0,   1, 1},  // pure blue sits on the upper hue bound
    '{8'd0,   8'd0,   8'd255, 1, 0},  // pure red, hue zero
    '{8'd128, 8'd128, 8'd128, 1, 0},  // gray
    '{8'd0,   8'd69,  8'd0,   1, 0},  // value just below its lower bound
    '{8'd0,   8'd70,  8'd0,   1, 1},  // value on its lower bound
    '{8'd1,   8'd0,   8'd255, 0, 0},  // hue rounds up to 180 and wraps to zero
    '{8'd0,   8'd200, 8'd200, 0, 0},  // red and green tie for the maximum
    '{8'd200, 8'd200, 8'd0,   0, 0},  // green and blue tie
    '{8'd2,   8'd1,   8'd0,   0, 0},  // tiny spread, blue maximum
    '{8'd255, 8'd0,   8'd255, 0, 0},  // magenta, negative hue wrapped
    '{8'd90,  8'd130, 8'd40,  0, 0}
  };

  initial begin
    blob_result_t res;
    logic [CFG_W-1:0] vals[8];
    int phase, count, burst, lo, span;
    logic [7:0] b, g, r;

    hue_lo = 60; sat_lo = 120; val_lo = 70;
    hue_hi = 120; sat_hi = 255; val_hi = 255;
    width_reg = 640; height_reg = 480;
    col_pos = 0; row_pos = 0;
    x_total = 0; y_total = 0; hit_count = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels against the reset bounds.
    foreach (directed[i]) begin
      send_pixel(directed[i].blue, directed[i].green, directed[i].red, res);
      if (directed[i].known) begin
        res = '0;
        res.in_range = directed[i].known_match;
      end
      pending_pixels.push_back(res);
    end

    // Phases of settings. The first few pin the size extremes, including a
    // size shrunk while a frame is under way; the rest are random.
    phase = 0;
    while (pixels_sent < PIXEL_GOAL) begin
      drain();
      lo = $urandom_range(90, 0);
      span = $urandom_range(255, 30);
      vals[REG_HUE_LOW] = lo;
      vals[REG_SAT_LOW] = $urandom_range(100, 0);
      vals[REG_VAL_LOW] = $urandom_range(100, 0);
      vals[REG_HUE_HIGH] = (lo + span > 180) ? 180 : lo + span;
      vals[REG_SAT_HIGH] = $urandom_range(255, 150);
      vals[REG_VAL_HIGH] = $urandom_range(255, 150);
      vals[REG_FRAME_WIDTH] = $urandom_range(8, 1);
      vals[REG_FRAME_HEIGHT] = $urandom_range(6, 1);
      count = $urandom_range(120, 20);
      case (phase)
        0: begin
          vals[REG_FRAME_WIDTH] = 0;
          vals[REG_FRAME_HEIGHT] = 0;
        end
        1: begin
          vals = '{12'd0, 12'd0, 12'd0, 12'd180, 12'd255, 12'd255, 12'd4095, 12'd4095};
          count = 60;
        end
        2: begin
          vals[REG_FRAME_WIDTH] = 3;
          vals[REG_FRAME_HEIGHT] = 2;
        end
        3: begin
          vals = '{12'd0, 12'd0, 12'd0, 12'd180, 12'd255, 12'd255, 12'd1, 12'd4095};
          count = 40;
        end
        4: begin
          vals[REG_FRAME_HEIGHT] = 2;
          vals[REG_FRAME_WIDTH] = 1;
        end
        5: begin
          vals = '{12'hFB4, 12'hF00, 12'hF00, 12'hF00, 12'hFFF, 12'hFFF, 12'd2048, 12'd2048};
          count = 30;
        end
        default: begin
          case ($urandom_range(9, 0))
            0: begin  // an empty bound
              vals[REG_HUE_LOW] = 120;
              vals[REG_HUE_HIGH] = 60;
            end
            1: vals[$urandom_range(5, 0)] = $urandom_range(4095, 0);
            2: vals[REG_FRAME_WIDTH] = $urandom_range(40, 9);
            default: ;
          endcase
        end
      endcase
      write_regs(vals);
      @(posedge clk);

      // Sender bursts with random gaps, occasionally none.
      while (count > 0) begin
        burst = $urandom_range(20, 1);
        while (burst > 0 && count > 0) begin
          b = $urandom_range(255, 0);
          g = $urandom_range(255, 0);
          r = $urandom_range(255, 0);
          if ($urandom_range(3, 0) == 0) begin
            // Strong greens mostly land inside the usual hue window.
            g = $urandom_range(255, 150);
            r = $urandom_range(80, 0);
            b = $urandom_range(120, 0);
          end
          send_pixel(b, g, r, res);
          pending_pixels.push_back(res);
          burst--;
          count--;
        end
        if ($urandom_range(2, 0) != 0) begin
          in_push <= 1'b0;
          repeat ($urandom_range(8, 1)) @(posedge clk);
        end
      end
      phase++;
    end

    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
